>>> rtl/usbdfu_pkg.sv
// usbdfu_pkg: request codes, dfu state and status codes, reply lengths and the
// request and result structs of the dfu request block
// no dependencies
package usbdfu_pkg;

    // dfu class request codes
    localparam logic [7:0] REQ_DETACH    = 8'd0;
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_UPLOAD    = 8'd2;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    // dfu state codes, as sent on the wire
    localparam logic [3:0] ST_APP_IDLE      = 4'd0;
    localparam logic [3:0] ST_APP_DETACH    = 4'd1;
    localparam logic [3:0] ST_DFU_IDLE      = 4'd2;
    localparam logic [3:0] ST_DNLOAD_IDLE   = 4'd5;
    localparam logic [3:0] ST_MANIFEST_WAIT = 4'd8;
    localparam logic [3:0] ST_DFU_ERROR     = 4'd10;

    // dfu status codes
    localparam logic [3:0] STAT_OK          = 4'd0;
    localparam logic [3:0] STAT_ERR_WRITE   = 4'd3;
    localparam logic [3:0] STAT_ERR_STALLED = 4'd15;

    // reply data lengths
    localparam logic [2:0] LEN_NONE      = 3'd0;
    localparam logic [2:0] LEN_GETSTATE  = 3'd1;
    localparam logic [2:0] LEN_GETSTATUS = 3'd6;

    typedef struct packed {
        logic [7:0] req_type;
        logic       dir_in;
        logic [7:0] length_low;
        logic       write_ok;
    } req_t;

    typedef struct packed {
        logic       handled;
        logic [2:0] reply_len;
        logic [3:0] reply_status;
        logic [3:0] reply_state;
        logic       write_strobe;
        logic       toggle_handlers;
    } result_t;

endpackage

>>> rtl/usb_dfu_request_fsm.sv
// usb_dfu_request_fsm: top level of the dfu class request block
// depends on usbdfu_pkg and usbdfu_decode
//
// usage
//   request channel: req_valid / req_stall carry one dfu class control
//   request per transaction (req_type, dir_in, length_low, write_ok)
//   response channel: rsp_valid / rsp_stall carry one result per request
//   (handled, reply_len, reply_status, reply_state, write_strobe,
//   toggle_handlers); handled low means stall the control endpoint
//   path: a taken request is held in the input register and decoded out of
//   it; its result is written to the output register once that register is
//   empty or being drained
//   throughput: one request per cycle unless the receiver stalls, set by
//   the combinational decode that reads and updates dfu state and status
//   reset: state goes to application idle, status to ok, both stages empty
//   receiver stall: the result holds in the output register; the input
//   register still takes one more request, then req_stall rises until the
//   output frees
module usb_dfu_request_fsm (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] req_type,
    input  logic       dir_in,
    input  logic [7:0] length_low,
    input  logic       write_ok,
    // response channel
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic       handled,
    output logic [2:0] reply_len,
    output logic [3:0] reply_status,
    output logic [3:0] reply_state,
    output logic       write_strobe,
    output logic       toggle_handlers
);

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    usbdfu_pkg::req_t    in_req_reg;

    // dfu state and status
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [3:0]          status_reg;
    logic [3:0]          status_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    usbdfu_pkg::result_t out_res_reg;
    usbdfu_pkg::result_t dec_res;

    logic                advance;
    logic                take_req;

    // the held request moves on when the result register is empty or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign take_req  = req_valid && !req_stall;

    usbdfu_decode u_decode (
        .req         (in_req_reg),
        .state       (state_reg),
        .status      (status_reg),
        .res         (dec_res),
        .state_next  (state_next),
        .status_next (status_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_req)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= usbdfu_pkg::ST_APP_IDLE;
            status_reg    <= usbdfu_pkg::STAT_OK;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg  <= state_next;
                status_reg <= status_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            in_req_reg.req_type   <= req_type;
            in_req_reg.dir_in     <= dir_in;
            in_req_reg.length_low <= length_low;
            in_req_reg.write_ok   <= write_ok;
        end
        if (advance)
        begin
            out_res_reg <= dec_res;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign handled         = out_res_reg.handled;
    assign reply_len       = out_res_reg.reply_len;
    assign reply_status    = out_res_reg.reply_status;
    assign reply_state     = out_res_reg.reply_state;
    assign write_strobe    = out_res_reg.write_strobe;
    assign toggle_handlers = out_res_reg.toggle_handlers;

endmodule

>>> rtl/usbdfu_decode.sv
// usbdfu_decode: request decode, next dfu state and status, reply selection
// depends on usbdfu_pkg
module usbdfu_decode (
    input  usbdfu_pkg::req_t    req,
    input  logic [3:0]          state,
    input  logic [3:0]          status,
    output usbdfu_pkg::result_t res,
    output logic [3:0]          state_next,
    output logic [3:0]          status_next
);

    always_comb
    begin
        res         = '0;
        state_next  = state;
        status_next = status;
        if (req.dir_in)
        begin
            case (req.req_type)
                usbdfu_pkg::REQ_UPLOAD:
                begin
                    status_next = usbdfu_pkg::STAT_ERR_STALLED;
                end
                usbdfu_pkg::REQ_GETSTATUS:
                begin
                    res.handled      = 1'b1;
                    res.reply_len    = usbdfu_pkg::LEN_GETSTATUS;
                    res.reply_status = status;
                    res.reply_state  = state;
                end
                usbdfu_pkg::REQ_GETSTATE:
                begin
                    res.handled     = 1'b1;
                    res.reply_len   = usbdfu_pkg::LEN_GETSTATE;
                    res.reply_state = state;
                end
                default:
                begin
                    // unknown in request: stall, nothing changes
                end
            endcase
        end
        else
        begin
            case (req.req_type)
                usbdfu_pkg::REQ_DETACH:
                begin
                    if (state == usbdfu_pkg::ST_APP_IDLE)
                    begin
                        res.toggle_handlers = 1'b1;
                        res.handled         = 1'b1;
                        state_next          = usbdfu_pkg::ST_APP_DETACH;
                    end
                    else
                    begin
                        status_next = usbdfu_pkg::STAT_ERR_STALLED;
                    end
                end
                usbdfu_pkg::REQ_DNLOAD:
                begin
                    if ((state == usbdfu_pkg::ST_DFU_IDLE ||
                         state == usbdfu_pkg::ST_DNLOAD_IDLE) && req.length_low != 8'd0)
                    begin
                        res.write_strobe = 1'b1;
                        if (!req.write_ok)
                        begin
                            status_next = usbdfu_pkg::STAT_ERR_WRITE;
                            state_next  = usbdfu_pkg::ST_DFU_ERROR;
                        end
                        else
                        begin
                            state_next  = usbdfu_pkg::ST_DNLOAD_IDLE;
                            res.handled = 1'b1;
                        end
                    end
                    else if (state == usbdfu_pkg::ST_DNLOAD_IDLE)
                    begin
                        // zero length block ends the download
                        res.toggle_handlers = 1'b1;
                        res.handled         = 1'b1;
                        state_next          = usbdfu_pkg::ST_MANIFEST_WAIT;
                    end
                    else
                    begin
                        status_next = usbdfu_pkg::STAT_ERR_STALLED;
                    end
                end
                usbdfu_pkg::REQ_CLRSTATUS:
                begin
                    if (state == usbdfu_pkg::ST_DFU_ERROR)
                    begin
                        status_next = usbdfu_pkg::STAT_OK;
                        state_next  = usbdfu_pkg::ST_DFU_IDLE;
                        res.handled = 1'b1;
                    end
                    else
                    begin
                        status_next = usbdfu_pkg::STAT_ERR_STALLED;
                    end
                end
                usbdfu_pkg::REQ_ABORT:
                begin
                    if (state != usbdfu_pkg::ST_APP_IDLE &&
                        state != usbdfu_pkg::ST_APP_DETACH)
                    begin
                        status_next = usbdfu_pkg::STAT_OK;
                        state_next  = usbdfu_pkg::ST_DFU_IDLE;
                        res.handled = 1'b1;
                    end
                    else
                    begin
                        status_next = usbdfu_pkg::STAT_ERR_STALLED;
                    end
                end
                default:
                begin
                    status_next = usbdfu_pkg::STAT_ERR_STALLED;
                end
            endcase
        end
    end

endmodule

>>> rtl/usbdfu_checker.sv
// usbdfu_checker: port level checks on the dfu request block, bound to the top
// depends on usbdfu_pkg and usb_dfu_request_fsm
module usbdfu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic       handled,
    input logic [2:0] reply_len,
    input logic [3:0] reply_status,
    input logic [3:0] reply_state,
    input logic       write_strobe,
    input logic       toggle_handlers
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(handled) && $stable(reply_len)
            && $stable(reply_status) && $stable(reply_state))
        else $error("stalled response changed");

    // no reply data means zeroed reply bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && reply_len == usbdfu_pkg::LEN_NONE |->
            reply_status == 4'd0 && reply_state == 4'd0)
        else $error("reply bytes set without reply data");

    // getstate reply carries no status and is always accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && reply_len == usbdfu_pkg::LEN_GETSTATE |->
            reply_status == 4'd0 && handled)
        else $error("bad getstate reply");

    // a stalled request never returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !handled |-> reply_len == usbdfu_pkg::LEN_NONE && !toggle_handlers)
        else $error("stalled request returned data or switched handlers");

    // a block write never coincides with a handler switch
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_strobe |-> !toggle_handlers)
        else $error("write strobe together with handler switch");

endmodule

bind usb_dfu_request_fsm usbdfu_checker u_usbdfu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .handled         (handled),
    .reply_len       (reply_len),
    .reply_status    (reply_status),
    .reply_state     (reply_state),
    .write_strobe    (write_strobe),
    .toggle_handlers (toggle_handlers)
);

>>> tb/sv/dfu_reply_checker_pkg.sv
// dfu_reply_checker_pkg: scoreboard for the dfu request block that tracks dfu state
// and status, predicts the result of every request and checks replies in order
// depends on usbdfu_pkg
package dfu_reply_checker_pkg;

    import usbdfu_pkg::*;

    class dfu_reply_checker;
        logic [3:0]  dfu_state_q;
        logic [3:0]  dfu_status_q;
        result_t     expected_replies[$];
        int unsigned mismatch_count;

        function new();
            dfu_state_q    = ST_APP_IDLE;
            dfu_status_q   = STAT_OK;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // next dfu state and status plus the reply for one request
        function result_t predict_reply(req_t r);
            result_t res;
            res = '0;
            if (r.dir_in)
            begin
                case (r.req_type)
                    REQ_UPLOAD:
                        dfu_status_q = STAT_ERR_STALLED;
                    REQ_GETSTATUS:
                    begin
                        res.handled      = 1'b1;
                        res.reply_len    = LEN_GETSTATUS;
                        res.reply_status = dfu_status_q;
                        res.reply_state  = dfu_state_q;
                    end
                    REQ_GETSTATE:
                    begin
                        res.handled     = 1'b1;
                        res.reply_len   = LEN_GETSTATE;
                        res.reply_state = dfu_state_q;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (r.req_type)
                    REQ_DETACH:
                        if (dfu_state_q == ST_APP_IDLE)
                        begin
                            res.toggle_handlers = 1'b1;
                            res.handled         = 1'b1;
                            dfu_state_q         = ST_APP_DETACH;
                        end
                        else
                            dfu_status_q = STAT_ERR_STALLED;
                    REQ_DNLOAD:
                        if ((dfu_state_q == ST_DFU_IDLE || dfu_state_q == ST_DNLOAD_IDLE)
                            && r.length_low != 8'd0)
                        begin
                            res.write_strobe = 1'b1;
                            if (!r.write_ok)
                            begin
                                dfu_status_q = STAT_ERR_WRITE;
                                dfu_state_q  = ST_DFU_ERROR;
                            end
                            else
                            begin
                                dfu_state_q = ST_DNLOAD_IDLE;
                                res.handled = 1'b1;
                            end
                        end
                        else if (dfu_state_q == ST_DNLOAD_IDLE && r.length_low == 8'd0)
                        begin
                            res.toggle_handlers = 1'b1;
                            res.handled         = 1'b1;
                            dfu_state_q         = ST_MANIFEST_WAIT;
                        end
                        else
                            dfu_status_q = STAT_ERR_STALLED;
                    REQ_CLRSTATUS:
                        if (dfu_state_q == ST_DFU_ERROR)
                        begin
                            dfu_status_q = STAT_OK;
                            dfu_state_q  = ST_DFU_IDLE;
                            res.handled  = 1'b1;
                        end
                        else
                            dfu_status_q = STAT_ERR_STALLED;
                    REQ_ABORT:
                        if (dfu_state_q != ST_APP_IDLE && dfu_state_q != ST_APP_DETACH)
                        begin
                            dfu_status_q = STAT_OK;
                            dfu_state_q  = ST_DFU_IDLE;
                            res.handled  = 1'b1;
                        end
                        else
                            dfu_status_q = STAT_ERR_STALLED;
                    default:
                        dfu_status_q = STAT_ERR_STALLED;
                endcase
            end
            return res;
        endfunction

        function void note_request(req_t r);
            expected_replies.push_back(predict_reply(r));
        endfunction

        function void log_failure(string msg);
            if (mismatch_count < 10)
                $display("%s", msg);
            mismatch_count++;
        endfunction

        function void check_reply(result_t got);
            result_t want;
            bit      bad;
            if (expected_replies.size() == 0)
            begin
                log_failure($sformatf("unexpected reply with no request pending at %0t",
                                      $time));
                return;
            end
            want = expected_replies.pop_front();
            bad  = (got.handled !== want.handled) || (got.reply_len !== want.reply_len)
                || (got.reply_status !== want.reply_status)
                || (got.reply_state !== want.reply_state)
                || (got.write_strobe !== want.write_strobe)
                || (got.toggle_handlers !== want.toggle_handlers);
            if (bad)
                log_failure($sformatf({"reply mismatch at %0t: expected ok=%0d len=%0d ",
                    "status=%0d state=%0d wr=%0d tog=%0d, got ok=%0d len=%0d status=%0d ",
                    "state=%0d wr=%0d tog=%0d"}, $time,
                    want.handled, want.reply_len, want.reply_status, want.reply_state,
                    want.write_strobe, want.toggle_handlers,
                    got.handled, got.reply_len, got.reply_status, got.reply_state,
                    got.write_strobe, got.toggle_handlers));
        endfunction
    endclass

endpackage

>>> tb/sv/tb_usb_dfu_request_fsm.sv
// tb_usb_dfu_request_fsm: top level testbench of the dfu class request block,
// directed and random requests under several idle and stall patterns
// depends on usbdfu_pkg, dfu_reply_checker_pkg and usb_dfu_request_fsm
module tb_usb_dfu_request_fsm;

    timeunit 1ns;
    timeprecision 1ps;

    import usbdfu_pkg::*;
    import dfu_reply_checker_pkg::*;

    // cycles with no transaction on either channel before the run is given up
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 150;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic [7:0] req_type;
    logic       dir_in;
    logic [7:0] length_low;
    logic       write_ok;
    logic       rsp_valid;
    logic       rsp_stall;
    logic       handled;
    logic [2:0] reply_len;
    logic [3:0] reply_status;
    logic [3:0] reply_state;
    logic       write_strobe;
    logic       toggle_handlers;

    result_t rsp_seen;

    // idling odds in percent, changed per phase
    int gap_pct;
    int stall_pct;
    int idle_cycles;

    dfu_reply_checker reply_board;

    usb_dfu_request_fsm uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_type        (req_type),
        .dir_in          (dir_in),
        .length_low      (length_low),
        .write_ok        (write_ok),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .handled         (handled),
        .reply_len       (reply_len),
        .reply_status    (reply_status),
        .reply_state     (reply_state),
        .write_strobe    (write_strobe),
        .toggle_handlers (toggle_handlers)
    );

    // packed in the same order as result_t
    assign rsp_seen = {handled, reply_len, reply_status, reply_state,
                       write_strobe, toggle_handlers};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stall, odds set by the current phase
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // response monitor: values read here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            reply_board.check_reply(rsp_seen);
    end

    // watchdog on transactions of either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic req_t make_req(logic [7:0] code, logic dir, logic [7:0] len,
                                      logic wr);
        req_t r;
        r.req_type   = code;
        r.dir_in     = dir;
        r.length_low = len;
        r.write_ok   = wr;
        return r;
    endfunction

    // mostly the defined codes, a quarter of any byte; before detach is allowed,
    // an out detach is turned into an in one so the block stays in application idle
    function automatic req_t random_req(bit allow_detach);
        req_t r;
        r.req_type   = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(6));
        r.dir_in     = 1'($urandom_range(1));
        r.length_low = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        r.write_ok   = 1'($urandom_range(1));
        if (!allow_detach && r.req_type == REQ_DETACH && !r.dir_in)
            r.dir_in = 1'b1;
        return r;
    endfunction

    // one request transaction, preceded by a random idle gap; called at a clock edge
    // and returns at the edge that took the request
    task automatic send_request(req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type   <= r.req_type;
        dir_in     <= r.dir_in;
        length_low <= r.length_low;
        write_ok   <= r.write_ok;
        req_valid  <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        reply_board.note_request(r);
    endtask

    // hold off the sender until every outstanding reply has come back
    task automatic drain_replies();
        req_valid <= 1'b0;
        while (reply_board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 88; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 88; end
            default: begin gap_pct = 32; stall_pct = 32; end
        endcase
    endtask

    initial
    begin
        reply_board = new();
        gap_pct     = 0;
        stall_pct   = 0;
        idle_cycles = 0;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req_type    <= 8'd0;
        dir_in      <= 1'b0;
        length_low  <= 8'd0;
        write_ok    <= 1'b0;
        rsp_stall   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part in application idle: status and state reads, upload,
        // unknown requests both ways, requests in the wrong state, length extremes
        set_idling(0);
        send_request(make_req(REQ_GETSTATUS, 1'b1, 8'd0,   1'b0));
        send_request(make_req(REQ_GETSTATE,  1'b1, 8'd255, 1'b1));
        send_request(make_req(REQ_UPLOAD,    1'b1, 8'd64,  1'b1));
        send_request(make_req(REQ_GETSTATUS, 1'b1, 8'd1,   1'b0));
        send_request(make_req(8'hff,         1'b1, 8'd255, 1'b0));
        send_request(make_req(8'd7,          1'b1, 8'd0,   1'b1));
        send_request(make_req(REQ_DETACH,    1'b1, 8'd0,   1'b0));
        send_request(make_req(REQ_ABORT,     1'b1, 8'd0,   1'b0));
        send_request(make_req(REQ_UPLOAD,    1'b0, 8'd16,  1'b1));
        send_request(make_req(REQ_GETSTATUS, 1'b0, 8'd0,   1'b1));
        send_request(make_req(REQ_GETSTATE,  1'b0, 8'd0,   1'b0));
        send_request(make_req(8'hff,         1'b0, 8'd255, 1'b1));
        send_request(make_req(REQ_DNLOAD,    1'b0, 8'd0,   1'b1));
        send_request(make_req(REQ_DNLOAD,    1'b0, 8'd255, 1'b0));
        send_request(make_req(REQ_DNLOAD,    1'b0, 8'd1,   1'b1));
        send_request(make_req(REQ_CLRSTATUS, 1'b0, 8'd0,   1'b0));
        send_request(make_req(REQ_ABORT,     1'b0, 8'd0,   1'b0));
        send_request(make_req(REQ_GETSTATUS, 1'b1, 8'd0,   1'b0));

        // detach is a one-way trip to application detach, so the first two phases
        // keep the block in application idle and detach only follows a drain
        for (int phase = 0; phase < 4; phase++)
        begin
            set_idling(phase);
            if (phase == 2)
            begin
                send_request(make_req(REQ_DETACH,    1'b0, 8'd0,   1'b0));
                send_request(make_req(REQ_GETSTATE,  1'b1, 8'd0,   1'b0));
                send_request(make_req(REQ_DETACH,    1'b0, 8'd255, 1'b1));
                send_request(make_req(REQ_DNLOAD,    1'b0, 8'd128, 1'b1));
                send_request(make_req(REQ_ABORT,     1'b0, 8'd0,   1'b1));
                send_request(make_req(REQ_CLRSTATUS, 1'b0, 8'd0,   1'b1));
                send_request(make_req(REQ_GETSTATUS, 1'b1, 8'd0,   1'b1));
            end
            repeat (ITEMS_PER_PHASE)
                send_request(random_req(phase >= 2));
            // pressure point: sender pauses until the pipeline is empty
            drain_replies();
        end

        // everything sent and answered; allow the two stage latency to settle
        repeat (4) @(posedge clk);
        if (reply_board.mismatch_count == 0 && reply_board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
